// File: rtl/lbp_pkg.sv
package lbp_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;

  localparam int unsigned PixW    = 8;
  localparam int unsigned PosW    = 10;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgW-1:0] WidthRst  = 11'd640;
  localparam logic [CfgW-1:0] HeightRst = 11'd480;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_e;

  // result slots in delivery order
  localparam int unsigned NumSlots     = 4;
  localparam int unsigned SlotIdxW     = 2;
  localparam int unsigned SlotColOne   = 0;
  localparam int unsigned SlotInterior = 1;
  localparam int unsigned SlotColLast  = 2;
  localparam int unsigned SlotEdgeRow  = 3;

  typedef struct packed {
    logic row_ge2;
    logic col_is1;
    logic col_ge2;
    logic col_last;
    logic edge_row;
    logic done;
  } sched_t;

  typedef struct packed {
    logic [PixW-1:0] code;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            border;
    logic            done;
  } res_t;

  typedef logic [8:0][PixW-1:0] win_t;

  // window index of the neighbour for each code bit, clockwise from nw
  localparam int unsigned NbrPos [8] = '{0, 1, 2, 5, 8, 7, 6, 3};

  function automatic logic [PixW-1:0] lbp_code(input win_t win);
    logic [PixW-1:0] code;
    code = '0;
    for (int b = 0; b < 8; b++) begin
      code[b] = (win[NbrPos[b]] >= win[4]);
    end
    return code;
  endfunction

endpackage

// File: rtl/lbp_pix_if.sv
interface lbp_pix_if import lbp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;
  logic            frame_start;

  modport source(output valid, pixel, frame_start, input ready);
  modport sink(input valid, pixel, frame_start, output ready);
endinterface

// File: rtl/lbp_res_if.sv
interface lbp_res_if import lbp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] code;
  logic [PosW-1:0] out_row;
  logic [PosW-1:0] out_col;
  logic            on_border;
  logic            last_of_run;
  logic            frame_done;

  modport source(output valid, code, out_row, out_col, on_border, last_of_run, frame_done,
                 input ready);
  modport sink(input valid, code, out_row, out_col, on_border, last_of_run, frame_done,
               output ready);
endinterface

// File: rtl/lbp_cfg_if.sv
interface lbp_cfg_if import lbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/lbp_ram.sv
module lbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lbp_pos.sv
module lbp_pos import lbp_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef,
  localparam int unsigned CW = $clog2(MaxWidth),
  localparam int unsigned RW = $clog2(MaxHeight)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lbp_cfg_if.sink       cfg_i,
  input  logic          accept_i,
  input  logic          frame_start_i,
  output logic [RW-1:0] row_o,
  output logic [CW-1:0] col_o,
  output sched_t        sched_o
);

  localparam int unsigned SWW = (CW + 1 > CfgW) ? CW + 1 : CfgW;
  localparam int unsigned SWH = (RW + 1 > CfgW) ? RW + 1 : CfgW;

  logic [CfgW-1:0] width_q, height_q;
  logic [CW-1:0]   col_q, col_d, col;
  logic [RW-1:0]   row_q, row_d, row;
  logic [SWW-1:0]  w, col_inc;
  logic [SWH-1:0]  h, row_pre, row_inc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        RegFrameWidth:  width_q  <= cfg_i.data;
        RegFrameHeight: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w = SWW'(width_q);
    if (w < SWW'(3)) begin
      w = SWW'(3);
    end else if (w > SWW'(MaxWidth)) begin
      w = SWW'(MaxWidth);
    end
    h = SWH'(height_q);
    if (h < SWH'(3)) begin
      h = SWH'(3);
    end else if (h > SWH'(MaxHeight)) begin
      h = SWH'(MaxHeight);
    end
  end

  // position of the arriving pixel, wrapping past a shrunk frame
  always_comb begin
    if (frame_start_i) begin
      col     = '0;
      row     = '0;
      row_pre = '0;
    end else begin
      if (SWW'(col_q) >= w) begin
        col     = '0;
        row_pre = SWH'(row_q) + SWH'(1);
      end else begin
        col     = col_q;
        row_pre = SWH'(row_q);
      end
      row = (row_pre >= h) ? '0 : RW'(row_pre);
    end
  end

  always_comb begin
    col_inc = SWW'(col) + SWW'(1);
    row_inc = SWH'(row) + SWH'(1);
    if (col_inc >= w) begin
      col_d = '0;
      row_d = (row_inc >= h) ? '0 : RW'(row_inc);
    end else begin
      col_d = CW'(col_inc);
      row_d = row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    sched_o.row_ge2  = (row >= RW'(2));
    sched_o.col_is1  = (col == CW'(1));
    sched_o.col_ge2  = (col >= CW'(2));
    sched_o.col_last = (SWW'(col) == w - SWW'(1));
    sched_o.edge_row = (row == '0) || (SWH'(row) == h - SWH'(1));
    sched_o.done     = (SWH'(row) == h - SWH'(1)) && (SWW'(col) == w - SWW'(1));
  end

  assign row_o = row;
  assign col_o = col;

endmodule

// File: rtl/lbp_emit.sv
module lbp_emit import lbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [NumSlots-1:0] mask_i,
  input  res_t                slots_i [NumSlots],
  output logic                free_o,
  lbp_res_if.source           res_o
);

  logic [NumSlots-1:0] mask_q, mask_d, mask_rest;
  res_t                slot_q [NumSlots];
  logic [SlotIdxW-1:0] sel;
  logic                last, fire, take;

  always_comb begin
    sel = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SlotIdxW'(i);
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - NumSlots'(1));
  assign last      = (mask_rest == '0);
  assign fire      = res_o.valid && res_o.ready;
  assign free_o    = (mask_q == '0) || (last && res_o.ready);
  assign take      = load_i && free_o;

  always_comb begin
    if (take) begin
      mask_d = mask_i;
    end else if (fire) begin
      mask_d = mask_rest;
    end else begin
      mask_d = mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q <= slots_i;
    end
  end

  assign res_o.valid       = (mask_q != '0);
  assign res_o.code        = slot_q[sel].code;
  assign res_o.out_row     = slot_q[sel].row;
  assign res_o.out_col     = slot_q[sel].col;
  assign res_o.on_border   = slot_q[sel].border;
  assign res_o.frame_done  = slot_q[sel].done;
  assign res_o.last_of_run = last;

endmodule

// File: rtl/lbp_3x3_code_stream.sv
// 3x3 local binary pattern over a raster pixel stream.
// pix_i carries one grayscale pixel per beat, frame_start marks pixel (0, 0).
// res_o carries results: an 8-bit code for interior pixels, or the source
// pixel with on_border set for border pixels, tagged with row and column.
// Row k is reported while row k+1 arrives; the first and last rows are
// reported as they arrive, the last one after the results of the row above.
// last_of_run marks the final result caused by one pixel, frame_done the
// result for the bottom-right pixel. cfg_i writes frame_width (index 0) and
// frame_height (index 1), clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT; write
// only while the block is idle.
// A pixel passes the line-store stage register, then the output sequencer register.
// Throughput: one pixel per cycle while each pixel yields at most one result
// and the receiver is ready; a pixel that yields n results holds the output
// until all n are sent by the one-result-per-cycle output sequencer. Both
// line stores share one single-port-read RAM, read and written once per pixel.
// Reset: position at (0, 0), window cleared, size 640 x 480; the line store
// is not cleared and needs no pass. A stalled receiver fills the output
// sequencer and the line-store stage, then drops pix_i.ready.
module lbp_3x3_code_stream import lbp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbp_cfg_if.sink   cfg_i,
  lbp_pix_if.sink   pix_i,
  lbp_res_if.source res_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned LineW = 2 * PixW;

  logic          accept, s1_adv, emit_free;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  sched_t        sched;

  logic            s1_valid_q;
  logic [PixW-1:0] s1_pix_q;
  logic [RW-1:0]   s1_row_q;
  logic [CW-1:0]   s1_col_q;
  sched_t          s1_sched_q;

  logic             fwd_q;
  logic [LineW-1:0] fwd_data_q;
  logic [LineW-1:0] rdata, line, wdata;
  logic [PixW-1:0]  up_pix, lo_pix;

  win_t                win_q, win_d;
  logic [NumSlots-1:0] mask;
  res_t                slots [NumSlots];
  logic [RW-1:0]       row_m1;
  logic [CW-1:0]       col_m1;

  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign accept      = pix_i.valid && pix_i.ready;
  assign s1_adv      = s1_valid_q && emit_free;

  lbp_pos #(
    .MaxWidth (MAX_WIDTH),
    .MaxHeight(MAX_HEIGHT)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .accept_i     (accept),
    .frame_start_i(pix_i.frame_start),
    .row_o        (row),
    .col_o        (col),
    .sched_o      (sched)
  );

  // one entry per column: {upper line, lower line}
  lbp_ram #(
    .Width(LineW),
    .Depth(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_col_q),
    .wdata_i(wdata),
    .re_i   (accept),
    .raddr_i(col),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (col == s1_col_q);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pix_i.pixel;
      s1_row_q   <= row;
      s1_col_q   <= col;
      s1_sched_q <= sched;
      fwd_data_q <= wdata;
    end
  end

  // bypass a write to the column read in the same cycle
  assign line   = fwd_q ? fwd_data_q : rdata;
  assign up_pix = line[LineW-1:PixW];
  assign lo_pix = line[PixW-1:0];
  assign wdata  = {lo_pix, s1_pix_q};

  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = up_pix;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = lo_pix;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  assign row_m1 = s1_row_q - RW'(1);
  assign col_m1 = s1_col_q - CW'(1);

  always_comb begin
    mask[SlotColOne]   = s1_sched_q.row_ge2 && s1_sched_q.col_is1;
    mask[SlotInterior] = s1_sched_q.row_ge2 && s1_sched_q.col_ge2;
    mask[SlotColLast]  = s1_sched_q.row_ge2 && s1_sched_q.col_last;
    mask[SlotEdgeRow]  = s1_sched_q.edge_row;

    slots[SlotColOne]   = '{code: win_d[4], row: PosW'(row_m1), col: '0,
                            border: 1'b1, done: 1'b0};
    slots[SlotInterior] = '{code: lbp_code(win_d), row: PosW'(row_m1),
                            col: PosW'(col_m1), border: 1'b0, done: 1'b0};
    slots[SlotColLast]  = '{code: win_d[5], row: PosW'(row_m1),
                            col: PosW'(s1_col_q), border: 1'b1, done: 1'b0};
    slots[SlotEdgeRow]  = '{code: s1_pix_q, row: PosW'(s1_row_q),
                            col: PosW'(s1_col_q), border: 1'b1, done: s1_sched_q.done};
  end

  lbp_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_valid_q),
    .mask_i (mask),
    .slots_i(slots),
    .free_o (emit_free),
    .res_o  (res_o)
  );

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.frame_done |-> res_o.last_of_run)
    else $error("frame_done without last_of_run");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel lost before line store stage");

  a_s1_drains_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s1_valid_q |-> s1_adv)
    else $error("pixel accepted over a held line store stage");

endmodule
